[rtl/core/ogrid_pkg.sv]
package ogrid_pkg;

	localparam int POS_W  = 24;
	localparam int CS_W   = 16;
	localparam int HT_W   = 16;
	localparam int HALF_W = 4;
	localparam int CFG_W  = 24;
	localparam int DIV_W  = 27;

	typedef struct packed {
		logic [2:0]              mode;
		logic signed [POS_W-1:0] point_x;
		logic signed [POS_W-1:0] point_y;
		logic signed [HT_W-1:0]  height;
		logic signed [POS_W-1:0] goal_x;
		logic signed [POS_W-1:0] goal_y;
		logic [7:0]              read_col;
		logic [7:0]              read_row;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] cell_code;
		logic       collision;
		logic [7:0] cell_col;
		logic [7:0] cell_row;
	} out_beat_t;

	localparam logic [2:0] MODE_CLEAR = 3'd0;
	localparam logic [2:0] MODE_OBST  = 3'd1;
	localparam logic [2:0] MODE_TRAV  = 3'd2;
	localparam logic [2:0] MODE_RAY   = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	localparam logic [1:0] CODE_UNKNOWN  = 2'd0;
	localparam logic [1:0] CODE_FREE     = 2'd1;
	localparam logic [1:0] CODE_OCCUPIED = 2'd2;
	localparam logic [1:0] CODE_NEAR     = 2'd3;

	localparam logic [2:0] CFG_ROBOT_X   = 3'd0;
	localparam logic [2:0] CFG_ROBOT_Y   = 3'd1;
	localparam logic [2:0] CFG_CELL_SIZE = 3'd2;
	localparam logic [2:0] CFG_OBST_H    = 3'd3;
	localparam logic [2:0] CFG_FLY_H     = 3'd4;
	localparam logic [2:0] CFG_HALF_X    = 3'd5;
	localparam logic [2:0] CFG_HALF_Y    = 3'd6;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LOC, S_RD, S_CHK, S_SCAN, S_WR,
		S_RAY_INIT, S_RAY_RD, S_RAY_CHK, S_OUT
	} state_t;

endpackage

[rtl/core/ogrid_ram.sv]
module ogrid_ram #(
	parameter int DW = 2,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/ogrid_locate.sv]
module ogrid_locate import ogrid_pkg::*; #(
	parameter int GRID_HALF_CELLS = 64,
	localparam int IW = $clog2(2 * GRID_HALF_CELLS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [POS_W-1:0] p,
	input  logic signed [POS_W-1:0] r,
	input  logic [CS_W-1:0]         csize,
	output logic                    done,
	output logic [IW-1:0]           idx
);

	localparam int WIDTH = 2 * GRID_HALF_CELLS + 1;
	localparam int CW = $clog2(DIV_W);

	logic              busy_q, fin_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_W-1:0]  num_q;
	logic [CS_W:0]     rem_q, div_q;
	logic              neg_q;
	logic [IW-1:0]     idx_q;
	logic signed [DIV_W-1:0] n;
	logic [CS_W+1:0]   trial;
	logic signed [DIV_W+1:0] sq, v;

	assign n = DIV_W'(DIV_W'($signed({p[POS_W-1], p} - {r[POS_W-1], r})) * 2
		+ $signed({{(DIV_W-CS_W){1'b0}}, csize}));
	assign trial = {rem_q, num_q[DIV_W-1]};

	always_comb begin
		sq = $signed({2'b00, num_q});
		if (neg_q) begin
			sq = -sq - ((rem_q != '0) ? (DIV_W+2)'(1) : (DIV_W+2)'(0));
		end
		v = sq + (DIV_W+2)'(GRID_HALF_CELLS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= n[DIV_W-1] ? DIV_W'(-n) : DIV_W'(n);
			neg_q <= n[DIV_W-1];
			rem_q <= '0;
			div_q <= {csize, 1'b0};
		end else if (busy_q) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q <= (CS_W+1)'(trial - {1'b0, div_q});
				num_q <= {num_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CS_W:0];
				num_q <= {num_q[DIV_W-2:0], 1'b0};
			end
		end
		if (fin_q) begin
			if (v < 0) begin
				idx_q <= '0;
			end else if (v > $signed((DIV_W+2)'(WIDTH - 1))) begin
				idx_q <= IW'(WIDTH - 1);
			end else begin
				idx_q <= v[IW-1:0];
			end
		end
	end

	assign done = done_q;
	assign idx  = idx_q;

endmodule

[rtl/core/occupancy_grid_marking_and_ray_check.sv]
// channel | direction | handshake          | payload
// in      | into      | in_valid/in_stall  | in_data (in_beat_t)
// out     | out of    | out_valid/out_stall| out_data (out_beat_t)
// cfg     | into      | cfg_we             | cfg_index, cfg_data
// Point items take two divider runs, ray queries four runs plus a read and check
// per visited cell, traversable points add a scan of the neighbor cells.
// The cell memory port sets the scan and walk rates; the shared divider sets locate.
// After reset and on a clear beat a clearing pass writes every cell, all (2H+1)^2
// of them (16641 at H=64), with in_stall high. One item is in work at a time;
// a finished result waits in the output register while the next beat is taken.
module occupancy_grid_marking_and_ray_check import ogrid_pkg::*; #(
	parameter int GRID_HALF_CELLS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_beat_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_beat_t        out_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int WIDTH  = 2 * GRID_HALF_CELLS + 1;
	localparam int NCELLS = WIDTH * WIDTH;
	localparam int IW     = $clog2(WIDTH);
	localparam int AW     = $clog2(NCELLS);
	localparam int XW     = IW + 6;
	localparam int EW     = 2 * IW;

	state_t state_q, state_d;
	in_beat_t in_q;

	logic signed [POS_W-1:0] robot_x_q, robot_y_q;
	logic [CS_W-1:0]         cell_size_q, cs_eff;
	logic signed [HT_W-1:0]  obst_h_q, fly_h_q;
	logic [HALF_W-1:0]       half_x_q, half_y_q;

	logic [1:0]    loc_sel_q, loc_last;
	logic          loc_go_q, loc_done;
	logic [IW-1:0] loc_idx;
	logic signed [POS_W-1:0] loc_p, loc_r;

	logic [IW-1:0] col_q, row_q, tcol_q, trow_q;
	logic [1:0]    code_q;
	logic          hit_q;

	logic signed [4:0] i_q, j_q;
	logic              end_q, pend_q, pend_hit, nb_in;
	logic signed [XW-1:0] xs, ys;

	logic [IW-1:0] cx_q, cy_q, ax_q, ay_q;
	logic          sxn_q, syn_q, step_x, at_goal, ray_hit;
	logic [EW-1:0] ex_q, ey_q;

	logic [AW-1:0] clr_cnt_q;
	logic          clr_out_q;

	out_beat_t out_q;
	logic      out_valid_q, out_load, trav_mark, in_band;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [1:0]    ram_wdata, ram_rdata;

	function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] c, input logic [IW-1:0] r);
		return AW'(c) * AW'(WIDTH) + AW'(r);
	endfunction

	ogrid_ram #(.DW(2), .DEPTH(NCELLS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cs_eff = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;

	always_comb begin
		unique case (loc_sel_q)
			2'd0: begin loc_p = in_q.point_x; loc_r = robot_x_q; end
			2'd1: begin loc_p = in_q.point_y; loc_r = robot_y_q; end
			2'd2: begin loc_p = in_q.goal_x;  loc_r = robot_x_q; end
			default: begin loc_p = in_q.goal_y; loc_r = robot_y_q; end
		endcase
	end

	ogrid_locate #(.GRID_HALF_CELLS(GRID_HALF_CELLS)) u_locate (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (loc_go_q),
		.p      (loc_p),
		.r      (loc_r),
		.csize  (cs_eff),
		.done   (loc_done),
		.idx    (loc_idx)
	);

	assign loc_last  = (in_q.mode == MODE_RAY) ? 2'd3 : 2'd1;
	assign in_band   = (in_q.height > obst_h_q) && (in_q.height < fly_h_q);
	assign trav_mark = (in_q.height <= obst_h_q) && (ram_rdata != CODE_OCCUPIED);
	assign pend_hit  = pend_q && (ram_rdata == CODE_OCCUPIED);

	assign xs = $signed({6'b0, col_q}) + $signed({{(IW+1){i_q[4]}}, i_q});
	assign ys = $signed({6'b0, row_q}) + $signed({{(IW+1){j_q[4]}}, j_q});
	assign nb_in = (xs >= 0) && (xs <= $signed(XW'(WIDTH - 1)))
		&& (ys >= 0) && (ys <= $signed(XW'(WIDTH - 1)));

	assign at_goal = (cx_q == tcol_q) && (cy_q == trow_q);
	assign ray_hit = (ram_rdata == CODE_OCCUPIED) || (ram_rdata == CODE_NEAR);
	assign step_x  = (ax_q == '0) ? 1'b0 : ((ay_q == '0) ? 1'b1 : (ex_q < ey_q));

	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cell_addr(col_q, row_q);
		ram_wdata = code_q;
		ram_raddr = cell_addr(col_q, row_q);
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = CODE_UNKNOWN;
				if (clr_cnt_q == AW'(NCELLS - 1)) begin
					state_d = clr_out_q ? S_OUT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_data.mode) inside
						MODE_CLEAR: state_d = S_CLR;
						MODE_OBST, MODE_TRAV, MODE_RAY: state_d = S_LOC;
						MODE_READ: state_d = S_RD;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_LOC: begin
				if (loc_done && loc_sel_q == loc_last) begin
					state_d = (in_q.mode == MODE_RAY) ? S_RAY_INIT : S_RD;
				end
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (in_q.mode == MODE_READ) begin
					state_d = S_OUT;
				end else if (in_q.mode == MODE_TRAV && trav_mark) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_WR;
				end
			end
			S_SCAN: begin
				ram_raddr = cell_addr(xs[IW-1:0], ys[IW-1:0]);
				if (end_q || pend_hit) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				ram_we  = 1'b1;
				state_d = S_OUT;
			end
			S_RAY_INIT: state_d = S_RAY_RD;
			S_RAY_RD: begin
				ram_raddr = cell_addr(cx_q, cy_q);
				state_d   = S_RAY_CHK;
			end
			S_RAY_CHK: begin
				ram_raddr = cell_addr(cx_q, cy_q);
				state_d   = (ray_hit || at_goal) ? S_OUT : S_RAY_RD;
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_x_q   <= '0;
			robot_y_q   <= '0;
			cell_size_q <= CS_W'(200);
			obst_h_q    <= HT_W'(150);
			fly_h_q     <= HT_W'(2000);
			half_x_q    <= HALF_W'(2);
			half_y_q    <= HALF_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROBOT_X:   robot_x_q   <= cfg_data[POS_W-1:0];
				CFG_ROBOT_Y:   robot_y_q   <= cfg_data[POS_W-1:0];
				CFG_CELL_SIZE: cell_size_q <= cfg_data[CS_W-1:0];
				CFG_OBST_H:    obst_h_q    <= cfg_data[HT_W-1:0];
				CFG_FLY_H:     fly_h_q     <= cfg_data[HT_W-1:0];
				CFG_HALF_X:    half_x_q    <= cfg_data[HALF_W-1:0];
				CFG_HALF_Y:    half_y_q    <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			clr_out_q   <= 1'b0;
			loc_go_q    <= 1'b0;
			loc_sel_q   <= '0;
			end_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			loc_go_q <= 1'b0;
			if (state_q == S_CLR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (state_q == S_IDLE && in_valid) begin
				clr_cnt_q <= '0;
				clr_out_q <= (in_data.mode == MODE_CLEAR);
				loc_sel_q <= '0;
				loc_go_q  <= (in_data.mode == MODE_OBST) || (in_data.mode == MODE_TRAV)
					|| (in_data.mode == MODE_RAY);
			end
			if (state_q == S_LOC && loc_done && loc_sel_q != loc_last) begin
				loc_sel_q <= loc_sel_q + 1'b1;
				loc_go_q  <= 1'b1;
			end
			if (state_q == S_CHK) begin
				end_q  <= 1'b0;
				pend_q <= 1'b0;
			end
			if (state_q == S_SCAN && !(end_q || pend_hit)) begin
				pend_q <= nb_in;
				if (i_q == $signed({1'b0, half_x_q}) && j_q == $signed({1'b0, half_y_q})) begin
					end_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					in_q   <= in_data;
					code_q <= CODE_UNKNOWN;
					hit_q  <= 1'b0;
					col_q  <= '0;
					row_q  <= '0;
					if (in_data.mode == MODE_READ) begin
						col_q <= (int'(in_data.read_col) > WIDTH - 1) ? IW'(WIDTH - 1)
							: IW'(in_data.read_col);
						row_q <= (int'(in_data.read_row) > WIDTH - 1) ? IW'(WIDTH - 1)
							: IW'(in_data.read_row);
					end
				end
			end
			S_LOC: begin
				if (loc_done) begin
					unique case (loc_sel_q)
						2'd0: col_q <= loc_idx;
						2'd1: row_q <= loc_idx;
						2'd2: tcol_q <= loc_idx;
						default: trow_q <= loc_idx;
					endcase
				end
			end
			S_CHK: begin
				code_q <= ram_rdata;
				if (in_q.mode == MODE_OBST && in_band) begin
					code_q <= CODE_OCCUPIED;
				end
				i_q <= -$signed({1'b0, half_x_q});
				j_q <= -$signed({1'b0, half_y_q});
			end
			S_SCAN: begin
				if (pend_hit) begin
					code_q <= CODE_NEAR;
				end else if (end_q) begin
					code_q <= CODE_FREE;
				end else if (j_q == $signed({1'b0, half_y_q})) begin
					j_q <= -$signed({1'b0, half_y_q});
					i_q <= i_q + 5'sd1;
				end else begin
					j_q <= j_q + 5'sd1;
				end
			end
			S_RAY_INIT: begin
				cx_q  <= col_q;
				cy_q  <= row_q;
				sxn_q <= tcol_q < col_q;
				syn_q <= trow_q < row_q;
				ax_q  <= (tcol_q < col_q) ? col_q - tcol_q : tcol_q - col_q;
				ay_q  <= (trow_q < row_q) ? row_q - trow_q : trow_q - row_q;
				ex_q  <= EW'((trow_q < row_q) ? row_q - trow_q : trow_q - row_q);
				ey_q  <= EW'((tcol_q < col_q) ? col_q - tcol_q : tcol_q - col_q);
			end
			S_RAY_CHK: begin
				if (ray_hit) begin
					hit_q <= 1'b1;
				end else if (!at_goal) begin
					if (step_x) begin
						cx_q <= sxn_q ? cx_q - 1'b1 : cx_q + 1'b1;
						ex_q <= ex_q + EW'(ay_q);
					end else begin
						cy_q <= syn_q ? cy_q - 1'b1 : cy_q + 1'b1;
						ey_q <= ey_q + EW'(ax_q);
					end
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.cell_code <= code_q;
			out_q.collision <= hit_q;
			out_q.cell_col  <= 8'(col_q);
			out_q.cell_row  <= 8'(row_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_clr_writes_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> ram_we && ram_wdata == CODE_UNKNOWN)
		else $error("clearing pass writes a nonzero code");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while an item is in work");

	a_locate_in_loc: assert property (@(posedge clk) disable iff (!arst_n)
		loc_done |-> state_q == S_LOC)
		else $error("locate result outside locate phase");

	a_hit_only_ray: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && hit_q |-> in_q.mode == MODE_RAY)
		else $error("collision reported for a non-ray item");

endmodule
